// ===== hw/rtl/chm_pkg.sv =====
// Shared types and constants for the chained hash multiset.
// Used by the top, controller and datapath modules; depends on nothing else.
package chm_pkg;

    // Fixed port widths.
    localparam int KEY_PORT_BITS = 16;
    localparam int CFG_BITS      = 5;
    localparam int REQ_BITS      = 2;

    // Bucket count used after reset and for a write of zero.
    localparam int DEFAULT_BUCKETS = 13;

    // Request codes.
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_QUERY  = 2'd2;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_EXEC = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic rd;
        logic exec;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } stat_t;

endpackage

// ===== hw/rtl/chained_hash_multiset_top.sv =====
// Top level of the chained hash multiset.
// Depends on chm_pkg; instantiates chm_ctrl and chm_datapath.
//
// Usage:
//   A request (req_type, key) is transferred at a rising edge where start
//   is high and busy is low. req_type selects insert, remove one copy or
//   query; other codes change nothing. The bucket is key modulo the bucket
//   count, and each bucket holds SLOTS_PER_BUCKET keys.
//   Exactly one result per request: done is high for one cycle and hit and
//   bucket_full are valid in that cycle. The receiver cannot stall, so the
//   result is taken at the edge that ends that cycle.
//   After its transfer a request passes the bit-serial remainder unit, one
//   key bit at a time over the used key width KW, then the bucket row is
//   read from the key RAM and written back. busy falls as done rises, so a
//   new request may follow in the cycle of the strobe.
//   bucket_count is written at any edge where bucket_count_we is high; the
//   user must write it only while idle, which the block does not enforce.
//   Zero selects the default of 13 and values above MAX_BUCKETS saturate.
//   Reset clears all slot valid flags at once and sets the bucket count to
//   its default; no clearing pass is needed.
module chained_hash_multiset_top
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS      = 16,
    parameter int SLOTS_PER_BUCKET = 4,
    parameter int KEY_BITS         = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [REQ_BITS-1:0]      req_type,
    input  logic [KEY_PORT_BITS-1:0] key,
    output logic                     done,
    output logic                     hit,
    output logic                     bucket_full,
    input  logic                     bucket_count_we,
    input  logic [CFG_BITS-1:0]      bucket_count
);

    cmd_t  cmd;
    stat_t stat;

    // Controller.
    chm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Datapath.
    chm_datapath #(
        .MAX_BUCKETS      (MAX_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .KEY_BITS         (KEY_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req_type),
        .key             (key),
        .bucket_count_we (bucket_count_we),
        .bucket_count    (bucket_count),
        .done            (done),
        .hit             (hit),
        .bucket_full     (bucket_full)
    );

endmodule

// ===== hw/rtl/chm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; depends on no package.
module chm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/chm_ctrl.sv =====
// Controller state machine for the chained hash multiset.
// Depends on chm_pkg for the state, command and status types.
module chm_ctrl
    import chm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Sequence: take the request, divide, read the bucket row, execute.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/chm_datapath.sv =====
// Datapath of the chained hash multiset: bucket count register, bit-serial
// remainder unit, slot valid flags, key row RAM and result registers.
// Depends on chm_pkg and instantiates chm_ram.
module chm_datapath
    import chm_pkg::*;
#(
    parameter int MAX_BUCKETS      = 16,
    parameter int SLOTS_PER_BUCKET = 4,
    parameter int KEY_BITS         = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic [REQ_BITS-1:0]      req_type,
    input  logic [KEY_PORT_BITS-1:0] key,
    input  logic                     bucket_count_we,
    input  logic [CFG_BITS-1:0]      bucket_count,
    output logic                     done,
    output logic                     hit,
    output logic                     bucket_full
);

    localparam int KW     = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
    localparam int BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int ROW_W  = SLOTS_PER_BUCKET * KW;
    localparam int BIT_CW = $clog2(KW);
    localparam int CFG_MAX = (1 << CFG_BITS) - 1;
    localparam logic [CFG_BITS-1:0] MAX_CNT =
        CFG_BITS'((MAX_BUCKETS > CFG_MAX) ? CFG_MAX : MAX_BUCKETS);
    localparam logic [CFG_BITS-1:0] DEF_CNT =
        CFG_BITS'((DEFAULT_BUCKETS > MAX_BUCKETS) ? MAX_BUCKETS : DEFAULT_BUCKETS);

    logic [CFG_BITS-1:0]         cnt_reg,    cnt_next;
    logic [REQ_BITS-1:0]         req_reg,    req_next;
    logic [KW-1:0]               key_reg,    key_next;
    logic [KW-1:0]               key_sh_reg, key_sh_next;
    logic [CFG_BITS-1:0]         rem_reg,    rem_next;
    logic [BIT_CW-1:0]           bit_reg,    bit_next;
    logic                        done_reg,   done_next;
    logic                        hit_reg,    hit_next;
    logic                        full_reg,   full_next;
    logic [SLOTS_PER_BUCKET-1:0] valid_reg [MAX_BUCKETS];

    logic [CFG_BITS:0]           trial;
    logic [BW-1:0]               addr;
    logic [ROW_W-1:0]            row_rdata;
    logic [ROW_W-1:0]            row_wdata;
    logic                        row_we;
    logic [SLOTS_PER_BUCKET-1:0] row_valid;
    logic [SLOTS_PER_BUCKET-1:0] row_valid_next;
    logic [SLOTS_PER_BUCKET-1:0] match;
    logic [SLOTS_PER_BUCKET-1:0] free;
    logic [SLOTS_PER_BUCKET-1:0] match_lo;
    logic [SLOTS_PER_BUCKET-1:0] free_lo;

    // Bucket count register: zero picks the default, large values saturate.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (bucket_count_we)
        begin
            if (bucket_count == '0)
            begin
                cnt_next = DEF_CNT;
            end
            else if (bucket_count > MAX_CNT)
            begin
                cnt_next = MAX_CNT;
            end
            else
            begin
                cnt_next = bucket_count;
            end
        end
    end

    // Restoring remainder: one key bit per cycle, most significant first.
    assign trial = {rem_reg, key_sh_reg[KW-1]};

    always_comb
    begin
        req_next    = req_reg;
        key_next    = key_reg;
        key_sh_next = key_sh_reg;
        rem_next    = rem_reg;
        bit_next    = bit_reg;
        if (cmd.load)
        begin
            req_next    = req_type;
            key_next    = key[KW-1:0];
            key_sh_next = key[KW-1:0];
            rem_next    = '0;
            bit_next    = BIT_CW'(KW - 1);
        end
        else if (cmd.div_step)
        begin
            key_sh_next = key_sh_reg << 1;
            bit_next    = bit_reg - 1'b1;
            if (trial >= {1'b0, cnt_reg})
            begin
                rem_next = CFG_BITS'(trial - {1'b0, cnt_reg});
            end
            else
            begin
                rem_next = trial[CFG_BITS-1:0];
            end
        end
    end

    assign stat.div_last = (bit_reg == '0);

    // The remainder is below the bucket count, so it always names a real row.
    assign addr = BW'(rem_reg);

    chm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_BUCKETS)
    ) u_key_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (addr),
        .wdata (row_wdata),
        .re    (cmd.rd),
        .raddr (addr),
        .rdata (row_rdata)
    );

    // Slot compare over the bucket row; keep only the lowest candidate.
    assign row_valid = valid_reg[addr];

    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            match[s] = row_valid[s] && (row_rdata[s*KW +: KW] == key_reg);
            free[s]  = !row_valid[s];
        end
    end

    assign match_lo = match & (~match + 1'b1);
    assign free_lo  = free & (~free + 1'b1);

    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            row_wdata[s*KW +: KW] = free_lo[s] ? key_reg : row_rdata[s*KW +: KW];
        end
    end

    // Request execution and result.
    always_comb
    begin
        row_we         = 1'b0;
        row_valid_next = row_valid;
        done_next      = cmd.exec;
        hit_next       = hit_reg;
        full_next      = full_reg;
        if (cmd.exec)
        begin
            hit_next  = 1'b0;
            full_next = 1'b0;
            case (req_reg)
                REQ_INSERT:
                begin
                    if (|free)
                    begin
                        row_we         = 1'b1;
                        row_valid_next = row_valid | free_lo;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    hit_next       = |match;
                    row_valid_next = row_valid & ~match_lo;
                end
                REQ_QUERY:
                begin
                    hit_next = |match;
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= DEF_CNT;
            done_reg <= 1'b0;
            for (int b = 0; b < MAX_BUCKETS; b++)
            begin
                valid_reg[b] <= '0;
            end
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            if (cmd.exec)
            begin
                valid_reg[addr] <= row_valid_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        key_reg    <= key_next;
        key_sh_reg <= key_sh_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
        hit_reg    <= hit_next;
        full_reg   <= full_next;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign bucket_full = full_reg;

endmodule

// ===== test/tb_chained_hash_multiset_top.sv =====
// Self-checking testbench for chained_hash_multiset_top: directed and random
// insert, remove and query transfers checked against a mirror of the hash table.
// Depends on chm_pkg and the chained_hash_multiset_top RTL only.
module tb_chained_hash_multiset_top;
    import chm_pkg::*;

    localparam int MAX_BUCKETS      = 16;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int KEY_BITS         = 16;
    localparam int TOTAL_SLOTS      = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES    = 25;
    localparam int TIMEOUT_CYCLES   = 400000;

    // Kinds of work the sender carries out, in queue order.
    typedef enum logic [1:0] {
        STEP_REQUEST,
        STEP_SET_BUCKETS,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t               kind;
        logic [REQ_BITS-1:0]      req;
        logic [KEY_PORT_BITS-1:0] key_val;
        logic [CFG_BITS-1:0]      count;
        int                       gap;
    } step_t;

    typedef struct packed {
        logic hit;
        logic full;
    } answer_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [REQ_BITS-1:0]      req_type = '0;
    logic [KEY_PORT_BITS-1:0] key = '0;
    logic                     done;
    logic                     hit;
    logic                     bucket_full;
    logic                     bucket_count_we = 1'b0;
    logic [CFG_BITS-1:0]      bucket_count = '0;

    // Mirror of the table contents and of the bucket count register.
    logic [KEY_PORT_BITS-1:0] mirror_key [TOTAL_SLOTS];
    logic                     mirror_live [TOTAL_SLOTS];
    int unsigned              mirror_buckets;

    step_t   sender_steps [$];
    answer_t pending_answers [$];
    int      idle_gap_max;
    bit      mismatch_seen = 1'b0;

    // Sender bookkeeping, owned by the driver.
    int      in_flight;
    int      wait_left;
    step_t   head;
    logic    next_start;
    logic    next_we;

    // Monitor working values.
    answer_t want;
    answer_t got;

    chained_hash_multiset_top #(
        .MAX_BUCKETS      (MAX_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .KEY_BITS         (KEY_BITS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .key             (key),
        .done            (done),
        .hit             (hit),
        .bucket_full     (bucket_full),
        .bucket_count_we (bucket_count_we),
        .bucket_count    (bucket_count)
    );

    always #5 clk = ~clk;

    // Applies one request to the mirror and returns the answer it should give.
    function automatic answer_t hash_table_op(logic [REQ_BITS-1:0] kind,
                                              logic [KEY_PORT_BITS-1:0] k);
        answer_t     r;
        int unsigned base;
        bit          found;
        r = '0;
        found = 1'b0;
        base = (int'(k) % mirror_buckets) * SLOTS_PER_BUCKET;
        case (kind)
            REQ_INSERT:
            begin
                r.full = 1'b1;
                for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                begin
                    if (!found && !mirror_live[base + s])
                    begin
                        mirror_key[base + s] = k;
                        mirror_live[base + s] = 1'b1;
                        found = 1'b1;
                        r.full = 1'b0;
                    end
                end
            end
            REQ_REMOVE:
            begin
                for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                begin
                    if (!found && mirror_live[base + s] && mirror_key[base + s] == k)
                    begin
                        mirror_live[base + s] = 1'b0;
                        found = 1'b1;
                        r.hit = 1'b1;
                    end
                end
            end
            REQ_QUERY:
            begin
                for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                begin
                    if (mirror_live[base + s] && mirror_key[base + s] == k)
                        r.hit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Zero selects the default and anything above the table size saturates.
    function automatic int unsigned clamp_buckets(logic [CFG_BITS-1:0] v);
        if (v == 0)
            return (DEFAULT_BUCKETS > MAX_BUCKETS) ? MAX_BUCKETS : DEFAULT_BUCKETS;
        else if (v > MAX_BUCKETS)
            return MAX_BUCKETS;
        else
            return 32'(v);
    endfunction

    task automatic add_request(logic [REQ_BITS-1:0] kind, logic [KEY_PORT_BITS-1:0] k);
        step_t st;
        st.kind = STEP_REQUEST;
        st.req = kind;
        st.key_val = k;
        st.count = '0;
        st.gap = (idle_gap_max == 0) ? 0 : $urandom_range(idle_gap_max, 0);
        sender_steps.push_back(st);
    endtask

    task automatic add_bucket_write(logic [CFG_BITS-1:0] v);
        step_t st;
        st.kind = STEP_SET_BUCKETS;
        st.req = '0;
        st.key_val = '0;
        st.count = v;
        st.gap = 0;
        sender_steps.push_back(st);
    endtask

    task automatic add_drain();
        step_t st;
        st.kind = STEP_DRAIN;
        st.req = '0;
        st.key_val = '0;
        st.count = '0;
        st.gap = 0;
        sender_steps.push_back(st);
    endtask

    // Driver: presents queued requests, holds each until its transfer, and
    // writes the bucket count only once every result has come back. Idle
    // cycles are counted only while the block is ready, so they are real gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_flight = 0;
            wait_left = 0;
            start <= 1'b0;
            req_type <= '0;
            key <= '0;
            bucket_count_we <= 1'b0;
            bucket_count <= '0;
        end
        else
        begin
            if (start && !busy)
                in_flight++;
            if (done)
                in_flight--;
            next_start = start && busy;
            next_we = 1'b0;
            if (!next_start)
            begin
                if (wait_left > 0)
                begin
                    if (!busy)
                        wait_left--;
                end
                else if (sender_steps.size() > 0)
                begin
                    head = sender_steps[0];
                    case (head.kind)
                        STEP_REQUEST:
                        begin
                            next_start = 1'b1;
                            req_type <= head.req;
                            key <= head.key_val;
                            wait_left = head.gap;
                            void'(sender_steps.pop_front());
                        end
                        STEP_SET_BUCKETS:
                        begin
                            if (in_flight == 0)
                            begin
                                next_we = 1'b1;
                                bucket_count <= head.count;
                                void'(sender_steps.pop_front());
                            end
                        end
                        default:
                        begin
                            if (in_flight == 0)
                                void'(sender_steps.pop_front());
                        end
                    endcase
                end
            end
            start <= next_start;
            bucket_count_we <= next_we;
        end
    end

    // Monitor: checks each result strobe against the oldest expectation, then
    // predicts for a transfer or a register write seen at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                got.hit = hit;
                got.full = bucket_full;
                if (pending_answers.size() == 0)
                begin
                    $error("result strobe with no request outstanding");
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit: expected %0b, actual %0b", want.hit, got.hit);
                        mismatch_seen = 1'b1;
                    end
                    if (got.full !== want.full)
                    begin
                        $error("bucket_full: expected %0b, actual %0b", want.full, got.full);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (start && !busy)
                pending_answers.push_back(hash_table_op(req_type, key));
            if (bucket_count_we)
                mirror_buckets = clamp_buckets(bucket_count);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [KEY_PORT_BITS-1:0] key_pool [12];
        logic [CFG_BITS-1:0]      bucket_plan [10];
        logic [REQ_BITS-1:0]      kind;
        logic [KEY_PORT_BITS-1:0] k;
        int                       roll;

        mirror_buckets = DEFAULT_BUCKETS;
        for (int i = 0; i < TOTAL_SLOTS; i++)
        begin
            mirror_key[i] = '0;
            mirror_live[i] = 1'b0;
        end

        // Directed part at the reset bucket count of 13.
        idle_gap_max = 3;
        add_request(REQ_QUERY, 16'd0);
        add_request(REQ_INSERT, 16'd0);
        add_request(REQ_INSERT, 16'd0);
        add_request(REQ_QUERY, 16'd0);
        add_request(REQ_REMOVE, 16'd0);
        add_request(REQ_REMOVE, 16'd0);
        add_request(REQ_REMOVE, 16'd0);
        add_request(REQ_UNUSED, 16'hFFFF);
        add_request(REQ_INSERT, 16'hFFFF);
        add_request(REQ_QUERY, 16'hFFFF);
        // Fill bucket five, then overflow it.
        add_request(REQ_INSERT, 16'd5);
        add_request(REQ_INSERT, 16'd18);
        add_request(REQ_INSERT, 16'd31);
        add_request(REQ_INSERT, 16'd44);
        add_request(REQ_INSERT, 16'd57);
        add_request(REQ_REMOVE, 16'd57);
        add_request(REQ_QUERY, 16'd44);
        // Change the count with keys stored: some now hash elsewhere.
        add_bucket_write(5'd16);
        add_request(REQ_QUERY, 16'd5);
        add_request(REQ_QUERY, 16'd18);
        add_bucket_write(5'd0);
        add_request(REQ_QUERY, 16'd18);
        add_bucket_write(5'd31);
        add_request(REQ_INSERT, 16'h8000);
        add_bucket_write(5'd1);
        add_request(REQ_INSERT, 16'h7FFF);
        add_request(REQ_QUERY, 16'h7FFF);

        // Random phases, each at its own bucket count; some run without gaps.
        bucket_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd7, 5'd13, 5'd3, 5'd0};
        bucket_plan[9] = CFG_BITS'($urandom_range(31, 0));
        for (int phase = 0; phase < 10; phase++)
        begin
            add_bucket_write(bucket_plan[phase]);
            idle_gap_max = (phase % 3 == 1) ? 0 : 13;
            for (int i = 0; i < 12; i++)
                key_pool[i] = KEY_PORT_BITS'($urandom_range(65535, 0));
            for (int i = 0; i < 200; i++)
            begin
                roll = $urandom_range(99, 0);
                if (roll < 45)
                    kind = REQ_INSERT;
                else if (roll < 75)
                    kind = REQ_REMOVE;
                else if (roll < 95)
                    kind = REQ_QUERY;
                else
                    kind = REQ_UNUSED;
                if ($urandom_range(9, 0) == 0)
                    k = KEY_PORT_BITS'($urandom_range(65535, 0));
                else
                    k = key_pool[$urandom_range(11, 0)];
                add_request(kind, k);
                if (i == 100 && phase % 4 == 2)
                    add_drain();
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every transfer and result, then let the block settle.
        while (sender_steps.size() != 0 || start || pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $error("%0d results never arrived", pending_answers.size());
            mismatch_seen = 1'b1;
        end
        if (!mismatch_seen)
            $display("chained_hash_multiset_top verification clean");
        else
            $display("chained_hash_multiset_top verification failed");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("chained_hash_multiset_top verification failed");
        $finish;
    end

endmodule

// ===== chained_hash_multiset_top.f =====
hw/rtl/chm_pkg.sv
hw/rtl/chm_ram.sv
hw/rtl/chm_ctrl.sv
hw/rtl/chm_datapath.sv
hw/rtl/chained_hash_multiset_top.sv
test/tb_chained_hash_multiset_top.sv
